>>> src/tlfd_pkg.sv
// Package for the typed-length frame deframer.
// Holds the phase and event codes and the result word type; no dependencies.
package tlfd_pkg;

   localparam int unsigned HEADER_BYTES = 3;

   typedef enum logic [2:0] {
      PH_TYPE         = 3'd0,
      PH_LEN_LO       = 3'd1,
      PH_LEN_HI       = 3'd2,
      PH_PAYLOAD      = 3'd3,
      PH_TAIL         = 3'd4,
      PH_DONE_PENDING = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EV_DATA = 2'd0,
      EV_DONE = 2'd1,
      EV_DROP = 2'd2
   } event_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  msg_type;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
   } rsp_word_type;

   // One received byte held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_item_type;

   // Result produced by the parser for one processed byte.
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } result_type;

endpackage

>>> src/tlfd_if.sv
// Valid/ready channel interfaces of the typed-length frame deframer.
// The request channel carries received bytes, the response channel events.
interface tlfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface tlfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [7:0]  msg_type;
   logic [7:0]  data_byte;
   logic [15:0] byte_index;
   logic [15:0] frame_length;

   modport source (output valid, output event_res, output msg_type, output data_byte,
                   output byte_index, output frame_length, input ready);
   modport sink (input valid, input event_res, input msg_type, input data_byte,
                 input byte_index, input frame_length, output ready);
endinterface

>>> src/tlfd_in_stage.sv
// Input register of the deframer: takes one word from the request channel.
// Depends on tlfd_pkg and tlfd_req_if.
module tlfd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   tlfd_req_if.sink             req_chan,
   input  logic                 advance,
   output tlfd_pkg::in_item_type item
);
   import tlfd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // A new word enters whenever the register is empty or drains this cycle.
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

>>> src/tlfd_parser.sv
// Frame parser of the deframer: phase machine, header fields and counters.
// Depends on tlfd_pkg; produces at most one result per processed word.
module tlfd_parser #(
   parameter int unsigned BUFFER_BYTES = 1024,
   parameter int unsigned TAIL_BYTES   = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   output tlfd_pkg::result_type  result
);
   import tlfd_pkg::*;

   localparam logic [17:0] OVERHEAD  = 18'(HEADER_BYTES + TAIL_BYTES);
   localparam logic [17:0] LIMIT     = 18'(BUFFER_BYTES);
   localparam logic [16:0] TAIL_LEN  = 17'(TAIL_BYTES);
   localparam logic        HAS_TAIL  = (TAIL_BYTES != 0);

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] count_ff, count_in;

   logic [15:0] len_full;
   logic        oversized;
   logic [16:0] count_next;

   assign len_full   = {rx_byte, len_ff[7:0]};
   assign oversized  = ({2'b00, len_full} + OVERHEAD) > LIMIT;
   assign count_next = {1'b0, count_ff} + 17'd1;

   // Next-state logic
   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      count_in = count_ff;
      unique case (phase_ff)
         PH_LEN_LO: begin
            len_in   = {8'd0, rx_byte};
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in   = len_full;
            count_in = '0;
            if (oversized) begin
               phase_in = PH_TYPE;
            end else if (len_full != 16'd0) begin
               phase_in = PH_PAYLOAD;
            end else if (!HAS_TAIL) begin
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_TAIL;
            end
         end
         PH_PAYLOAD: begin
            count_in = count_next[15:0];
            if (count_next >= {1'b0, len_ff}) begin
               if (HAS_TAIL) begin
                  phase_in = PH_TAIL;
                  count_in = '0;
               end else begin
                  phase_in = PH_DONE_PENDING;
               end
            end
         end
         PH_TAIL: begin
            count_in = count_next[15:0];
            if (count_next >= TAIL_LEN) begin
               phase_in = PH_TYPE;
               count_in = '0;
            end
         end
         default: begin
            // Type byte, also taken in the pending phase, whose step gives the frame-done event.
            type_in  = rx_byte;
            phase_in = PH_LEN_LO;
         end
      endcase
   end

   // Output logic
   always_comb begin
      result.valid                = 1'b0;
      result.word.event_res       = EV_DATA;
      result.word.msg_type        = type_ff;
      result.word.data_byte       = 8'd0;
      result.word.byte_index      = 16'd0;
      result.word.frame_length    = len_ff;
      unique case (phase_ff)
         PH_DONE_PENDING: begin
            result.valid          = 1'b1;
            result.word.event_res = EV_DONE;
         end
         PH_LEN_HI: begin
            result.word.frame_length = len_full;
            if (oversized) begin
               result.valid          = 1'b1;
               result.word.event_res = EV_DROP;
            end else if (len_full == 16'd0 && !HAS_TAIL) begin
               result.valid          = 1'b1;
               result.word.event_res = EV_DONE;
            end
         end
         PH_PAYLOAD: begin
            result.valid           = 1'b1;
            result.word.event_res  = EV_DATA;
            result.word.data_byte  = rx_byte;
            result.word.byte_index = count_ff;
         end
         PH_TAIL: begin
            if (count_next >= TAIL_LEN) begin
               result.valid          = 1'b1;
               result.word.event_res = EV_DONE;
            end
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         type_ff  <= '0;
         len_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   a_payload_gives_data: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (result.valid && result.word.event_res == EV_DATA))
      else $error("payload word without data event");

   a_tail_only_done: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TAIL && result.valid) |-> (result.word.event_res == EV_DONE))
      else $error("tail word gave an event other than frame done");

   a_drop_rehunts: assert property (@(posedge clock) disable iff (reset)
      (step && result.valid && result.word.event_res == EV_DROP) |=> (phase_ff == PH_TYPE))
      else $error("drop event not followed by type hunt");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (count_ff < len_ff))
      else $error("payload counter ran past frame length");

endmodule

>>> src/tlfd_out_stage.sv
// Result register of the deframer: holds one event word for the response channel.
// Depends on tlfd_pkg and tlfd_rsp_if.
module tlfd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  tlfd_pkg::result_type result,
   tlfd_rsp_if.source           rsp_chan,
   output logic                 free
);
   import tlfd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;
   logic         load;

   assign free = !valid_ff || rsp_chan.ready;
   assign load = step && result.valid;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result.word;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.event_res    = word_ff.event_res;
   assign rsp_chan.msg_type     = word_ff.msg_type;
   assign rsp_chan.data_byte    = word_ff.data_byte;
   assign rsp_chan.byte_index   = word_ff.byte_index;
   assign rsp_chan.frame_length = word_ff.frame_length;

endmodule

>>> src/typed_length_frame_deframer_core.sv
// Typed-length frame deframer: takes one received byte per word and sends
// an event word for each payload byte, each completed frame and each drop.
// Depends on tlfd_pkg, tlfd_if, tlfd_in_stage, tlfd_parser and tlfd_out_stage.
//
// The block accepts one byte every clock cycle while input is not stalled. A
// byte is held in the input register and is parsed while moving into the
// result register, from which its event is offered on the response channel.
// Throughput is set only by the result register: input stalls only while an
// event waits there and the response side is not ready. Frames are a type
// byte, a little-endian 16-bit length, the payload and TAIL_BYTES unchecked
// tail bytes; a header whose total size exceeds BUFFER_BYTES gives a drop
// event and the next byte is taken as a new type byte.
module typed_length_frame_deframer_core #(
   parameter int unsigned BUFFER_BYTES = 1024,
   parameter int unsigned TAIL_BYTES   = 9
) (
   input  logic        clock,
   input  logic        reset,
   tlfd_req_if.sink    req_chan,
   tlfd_rsp_if.source  rsp_chan
);
   import tlfd_pkg::*;

   in_item_type item;
   result_type  result;
   logic        free;
   logic        advance;

   assign advance = item.valid && free;

   tlfd_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .item     (item)
   );

   tlfd_parser #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .TAIL_BYTES   (TAIL_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (item.rx_byte),
      .result  (result)
   );

   tlfd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .result   (result),
      .rsp_chan (rsp_chan),
      .free     (free)
   );

endmodule

>>> dv/typed_length_frame_deframer_core_test.sv
// Self-checking testbench for typed_length_frame_deframer_core: drives byte streams of
// well-formed, oversized and broken frames and checks every event word against a predictor.
// Depends on tlfd_pkg, tlfd_if and the deframer core.
module typed_length_frame_deframer_core_test;
   import tlfd_pkg::*;

   localparam int unsigned BUFFER_BYTES  = 1024;
   localparam int unsigned TAIL_BYTES    = 9;
   localparam int unsigned MAX_LEN       = BUFFER_BYTES - HEADER_BYTES - TAIL_BYTES;
   localparam int unsigned RANDOM_BYTES  = 1000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned IDLE_LIMIT    = 3000;
   localparam int unsigned DRAIN_CYCLES  = 10;

   typedef enum {RX_ALWAYS, RX_COIN, RX_EVERY_THIRD, RX_STALLS} rx_mode_type;

   // Tracks the frame parser state and holds the event words that are still due.
   class frame_event_book;
      phase_type    phase;
      logic [7:0]   frame_type;
      logic [15:0]  frame_len;
      logic [15:0]  count;
      rsp_word_type due_events[$];
      int unsigned  failures;

      function new();
         phase      = PH_TYPE;
         frame_type = '0;
         frame_len  = '0;
         count      = '0;
         failures   = 0;
      endfunction

      function void queue_event(event_type ev, logic [7:0] data, logic [15:0] idx);
         rsp_word_type w;
         w.event_res    = ev;
         w.msg_type     = frame_type;
         w.data_byte    = data;
         w.byte_index   = idx;
         w.frame_length = frame_len;
         due_events.push_back(w);
      endfunction

      function void take_byte(logic [7:0] b);
         logic [15:0] idx;
         int unsigned total;
         case (phase)
            PH_DONE_PENDING: begin
               queue_event(EV_DONE, 8'h00, 16'h0000);
               frame_type = b;
               phase      = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               frame_len = {8'h00, b};
               phase     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               frame_len[15:8] = b;
               count = '0;
               total = HEADER_BYTES + frame_len + TAIL_BYTES;
               if (total > BUFFER_BYTES) begin
                  phase = PH_TYPE;
                  queue_event(EV_DROP, 8'h00, 16'h0000);
               end else if (frame_len != 0) begin
                  phase = PH_PAYLOAD;
               end else if (TAIL_BYTES == 0) begin
                  phase = PH_TYPE;
                  queue_event(EV_DONE, 8'h00, 16'h0000);
               end else begin
                  phase = PH_TAIL;
               end
            end
            PH_PAYLOAD: begin
               idx   = count;
               count = count + 16'd1;
               if (count >= frame_len) begin
                  if (TAIL_BYTES == 0) begin
                     phase = PH_DONE_PENDING;
                  end else begin
                     count = '0;
                     phase = PH_TAIL;
                  end
               end
               queue_event(EV_DATA, b, idx);
            end
            PH_TAIL: begin
               count = count + 16'd1;
               if (count >= TAIL_BYTES) begin
                  phase = PH_TYPE;
                  count = '0;
                  queue_event(EV_DONE, 8'h00, 16'h0000);
               end
            end
            default: begin
               frame_type = b;
               phase      = PH_LEN_LO;
            end
         endcase
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_event(rsp_word_type got);
         rsp_word_type want;
         if (due_events.size() == 0) begin
            $error("event_res: expected no event, got %0h", got.event_res);
            failures++;
            return;
         end
         want = due_events.pop_front();
         check_field("event_res", 16'(want.event_res), 16'(got.event_res));
         check_field("msg_type", 16'(want.msg_type), 16'(got.msg_type));
         check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
         check_field("byte_index", want.byte_index, got.byte_index);
         check_field("frame_length", want.frame_length, got.frame_length);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlfd_req_if req_chan ();
   tlfd_rsp_if rsp_chan ();

   typed_length_frame_deframer_core #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .TAIL_BYTES  (TAIL_BYTES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   frame_event_book book = new();

   int unsigned bytes_sent  = 0;
   int unsigned burst_left  = 0;
   int unsigned idle_cycles = 0;
   bit          gaps_on     = 1'b1;
   bit          hold_req    = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Both channels are sampled at the edge, before any driver update lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            book.take_byte(req_chan.rx_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            book.check_event({rsp_chan.event_res, rsp_chan.msg_type, rsp_chan.data_byte,
                              rsp_chan.byte_index, rsp_chan.frame_length});
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   // Sends a frame header; the payload and tail follow only when the frame fits.
   // With stripes set the payload alternates between all zeros and all ones.
   task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                             input bit stripes);
      send_byte(ftype);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      if (HEADER_BYTES + len + TAIL_BYTES <= BUFFER_BYTES) begin
         for (int unsigned i = 0; i < len; i++) begin
            if (stripes) send_byte(i[0] ? 8'hFF : 8'h00);
            else send_byte(8'($urandom_range(0, 255)));
         end
         for (int unsigned i = 0; i < TAIL_BYTES; i++) begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin : receiver
      rx_mode_type mode;
      int unsigned mode_left, hold_left, stall_left, tick;
      mode       = RX_ALWAYS;
      mode_left  = 0;
      hold_left  = 0;
      stall_left = 0;
      tick       = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               RX_ALWAYS: rsp_chan.ready <= 1'b1;
               RX_COIN: rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_EVERY_THIRD: rsp_chan.ready <= (tick % 3 == 0);
               default: begin
                  if (stall_left != 0) begin
                     stall_left--;
                     rsp_chan.ready <= 1'b0;
                  end else begin
                     rsp_chan.ready <= 1'b1;
                     if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 20);
                  end
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      int unsigned r, n, stop_at;
      bit          did_max, did_hold;
      logic [15:0] len;
      did_max  = 1'b0;
      did_hold = 1'b0;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty payload straight into the tail, an oversized header with the
      // largest length, then a short frame of all-zero and all-one bytes.
      send_frame(8'hFF, 16'd0, 1'b0);
      send_frame(8'h00, 16'hFFFF, 1'b0);
      send_frame(8'hA5, 16'd2, 1'b1);

      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) begin
         gaps_on = !(bytes_sent > 200 && bytes_sent < 350);
         if (!did_hold && bytes_sent >= 500) begin
            did_hold = 1'b1;
            hold_req = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 68) begin
            send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 16)), 1'b0);
         end else if (r < 74) begin
            send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(17, 120)), 1'b0);
         end else if (r < 82) begin
            // Oversized headers, often right at the first length that no longer fits.
            len = $urandom_range(0, 1) ? 16'(MAX_LEN + 1) : 16'($urandom_range(MAX_LEN + 1, 65535));
            send_frame(8'($urandom_range(0, 255)), len, 1'b0);
         end else if (r < 84 && !did_max) begin
            did_max = 1'b1;
            send_frame(8'($urandom_range(0, 255)), 16'(MAX_LEN), 1'b0);
         end else if (r < 92) begin
            // A frame cut short inside its payload or tail, after an empty-payload frame.
            send_frame(8'($urandom_range(0, 255)), 16'd0, 1'b0);
            n = $urandom_range(1, 3);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'h00);
            for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
         end else begin
            n = $urandom_range(1, 6);
            for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
         end
      end
      req_chan.valid <= 1'b0;

      // Let the last accepted byte reach the predictor before checking for due events.
      @(posedge clock);
      while (book.due_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (book.failures == 0 && book.due_events.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
